[hdl/rgt_pkg.sv]
// rgt_pkg: shared types, constants and helpers of the glyph text renderer.
// Used by rgt_div, rgt_datapath, rgt_ctrl and rle_glyph_text_renderer_top.
package rgt_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int TAB_STOP   = 4;
    localparam int MAX_RUN    = 64;

    localparam logic [10:0] ROW_MAX  = 11'd2047;
    localparam logic [20:0] ADDR_MAX = 21'h1FFFFF;

    // column divider: 11-bit dividend, one quotient bit per cycle
    localparam int DIV_BITS  = 11;
    localparam int DIV_CNT_W = $clog2(DIV_BITS + 1);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TILDE = 8'h7E;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        CMD_CHAR = 2'd0,
        CMD_RUN  = 2'd1,
        CMD_SET  = 2'd2
    } item_cmd_t;

    typedef enum logic [1:0] {
        CFG_WIDTH  = 2'd0,
        CFG_HEIGHT = 2'd1,
        CFG_COLOR  = 2'd2,
        CFG_GAP    = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        CK_INVALID,
        CK_SPACE,
        CK_LF,
        CK_CR,
        CK_TAB,
        CK_GLYPH
    } char_kind_t;

    // source of the column/row handed to the cursor placement
    typedef enum logic [2:0] {
        PS_CURSOR,
        PS_SETPOS,
        PS_SPACE,
        PS_LF,
        PS_CR,
        PS_TAB,
        PS_GLYPH
    } place_src_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREA,
        S_GMUL,
        S_CHECK,
        S_DIV,
        S_DISPATCH,
        S_WRAP1,
        S_WRAP2,
        S_AMUL,
        S_OPEN,
        S_RUN,
        S_FLUSH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic       accept;
        logic       area_mul;
        logic       glyph_mul;
        logic       addr_mul;
        logic       clr_glyph;
        logic       div_start;
        place_src_t src;
        logic       place;
        logic       wrap1;
        logic       wrap2;
        logic       open_glyph;
        logic       pix_step;
        logic       flush;
    } rgt_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] item_cmd;
        char_kind_t char_kind;
        logic       glyph_big;
        logic       glyph_active;
        logic       div_done;
        logic       run_done;
        logic       pix_stall;
        logic       pend_valid;
        logic       out_free;
    } rgt_sts_t;

    function automatic char_kind_t classify(input logic [7:0] c);
        char_kind_t k;
        if (c == CHAR_SPACE) begin
            k = CK_SPACE;
        end else if (c == CHAR_LF) begin
            k = CK_LF;
        end else if (c == CHAR_CR) begin
            k = CK_CR;
        end else if (c == CHAR_TAB) begin
            k = CK_TAB;
        end else if (c inside {[CHAR_SPACE:CHAR_TILDE]}) begin
            k = CK_GLYPH;
        end else begin
            k = CK_INVALID;
        end
        return k;
    endfunction

endpackage

[hdl/rgt_div.sv]
// rgt_div: restoring divider, one quotient bit per cycle.
// Splits a cursor column into row carry and column. Depends on rgt_pkg.
module rgt_div
    import rgt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [DIV_BITS-1:0] num,
    input  logic [DIV_BITS-1:0] divisor,
    output logic                done,
    output logic [DIV_BITS-1:0] quot,
    output logic [9:0]          rem
);

    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_BITS-1:0]  rem_reg;
    logic [DIV_BITS-1:0]  quot_reg;
    logic [DIV_BITS:0]    shifted;
    logic                 ge;
    logic [DIV_BITS:0]    diff;

    // remainder stays below the divisor (at most 1024), so shifted never sets its top bit
    assign shifted = {rem_reg, quot_reg[DIV_BITS-1]};
    assign ge      = shifted >= {1'b0, divisor};
    assign diff    = shifted - {1'b0, divisor};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (start) begin
            cnt_reg <= DIV_CNT_W'(DIV_BITS);
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            quot_reg <= num;
        end else if (cnt_reg != '0) begin
            rem_reg  <= ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
            quot_reg <= {quot_reg[DIV_BITS-2:0], ge};
        end
    end

    assign done = (cnt_reg == '0);
    assign quot = quot_reg;
    assign rem  = rem_reg[9:0];

endmodule

[hdl/rgt_datapath.sv]
// rgt_datapath: config registers, cursor, shared multiplier, glyph state,
// pixel walker and output staging. Depends on rgt_pkg and rgt_div.
module rgt_datapath
    import rgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  rgt_ctl_t    ctl,
    output rgt_sts_t    sts,
    input  logic [59:0] in_data,
    input  logic [1:0]  in_kind,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [19:0] out_address,
    output logic [15:0] out_color,
    output logic        out_last,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    // configuration
    logic [10:0] width_reg, height_reg;
    logic [15:0] color_reg;
    logic [7:0]  gap_reg;
    logic [10:0] w_eff, h_eff;

    // captured item
    logic [1:0]  cmd_reg;
    logic [7:0]  char_reg, gw_reg, gh_reg, yoff_reg;
    logic        paint_reg;
    logic [9:0]  pos_x_reg, pos_y_reg;
    logic [6:0]  run_left_reg;
    logic [6:0]  run_len;

    // arithmetic
    logic [12:0] mul_a;
    logic [10:0] mul_b;
    logic [23:0] mul_out;
    logic [23:0] prod_reg;
    logic [20:0] area_reg;

    // cursor and placement
    logic [9:0]  cursor_col_reg;
    logic [10:0] cursor_row_reg;
    logic [11:0] row_base_reg;
    logic [9:0]  wcol_reg;
    logic [11:0] wrow_reg;
    logic [10:0] div_num;
    logic [11:0] div_row;
    logic        div_done;
    logic [10:0] div_quot;
    logic [9:0]  div_rem;
    logic [12:0] row_sum;
    logic [11:0] row_next_line;
    logic [10:0] wrap_col_sum;
    logic [12:0] wrap_row_sum;
    logic [24:0] open_addr;

    // glyph state and pixel walker
    logic [20:0] draw_addr_reg;
    logic [7:0]  row_pos_reg, row_size_reg;
    logic        glyph_active_reg;
    logic [21:0] pix_addr;
    logic        emit;
    logic        out_free;
    logic [8:0]  rp_inc;
    logic        row_end;
    logic [21:0] da_step;
    logic [20:0] da_next;

    // output staging: one held write (to learn which is last) plus the output register
    logic        pend_valid_reg;
    logic [19:0] pend_addr_reg;
    logic        out_valid_reg;
    logic [19:0] out_addr_reg;
    logic [15:0] out_color_reg;
    logic        out_last_reg;
    logic        load_out;

    always_comb begin
        if (width_reg == '0) begin
            w_eff = 11'd1;
        end else if (width_reg > 11'(MAX_WIDTH)) begin
            w_eff = 11'(MAX_WIDTH);
        end else begin
            w_eff = width_reg;
        end
        if (height_reg == '0) begin
            h_eff = 11'd1;
        end else if (height_reg > 11'(MAX_HEIGHT)) begin
            h_eff = 11'(MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= 11'd320;
            height_reg <= 11'd240;
            color_reg  <= 16'hFFFF;
            gap_reg    <= 8'd0;
        end else if (cfg_wr_en) begin
            case (cfg_index_t'(cfg_index))
                CFG_WIDTH:  width_reg  <= cfg_wdata[10:0];
                CFG_HEIGHT: height_reg <= cfg_wdata[10:0];
                CFG_COLOR:  color_reg  <= cfg_wdata;
                CFG_GAP:    gap_reg    <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // item capture
    assign run_len = (in_data[38:32] > 7'(MAX_RUN)) ? 7'(MAX_RUN) : in_data[38:32];

    always_ff @(posedge aclk) begin
        if (ctl.accept) begin
            cmd_reg   <= in_kind;
            char_reg  <= in_data[7:0];
            gw_reg    <= in_data[15:8];
            gh_reg    <= in_data[23:16];
            yoff_reg  <= in_data[31:24];
            paint_reg <= in_data[39];
            pos_x_reg <= in_data[49:40];
            pos_y_reg <= in_data[59:50];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_left_reg <= '0;
        end else if (ctl.accept) begin
            run_left_reg <= run_len;
        end else if (ctl.pix_step) begin
            run_left_reg <= run_left_reg - 1'b1;
        end
    end

    // shared multiplier: screen area, glyph area, glyph start row times stride
    always_comb begin
        if (ctl.area_mul) begin
            mul_a = {2'b0, w_eff};
            mul_b = h_eff;
        end else if (ctl.glyph_mul) begin
            mul_a = {5'b0, gw_reg};
            mul_b = {3'b0, gh_reg};
        end else begin
            mul_a = 13'(wrow_reg) + 13'(yoff_reg);
            mul_b = w_eff;
        end
    end

    assign mul_out = 24'(mul_a) * 24'(mul_b);

    always_ff @(posedge aclk) begin
        if (ctl.area_mul) begin
            area_reg <= mul_out[20:0];
        end
        if (ctl.glyph_mul || ctl.addr_mul) begin
            prod_reg <= mul_out;
        end
    end

    // placement source select
    assign row_next_line = 12'(cursor_row_reg) + 12'd1 + 12'(gap_reg);

    always_comb begin
        case (ctl.src)
            PS_SETPOS: begin
                div_num = {1'b0, pos_x_reg};
                div_row = {2'b0, pos_y_reg};
            end
            PS_SPACE: begin
                div_num = 11'(cursor_col_reg) + 11'(gw_reg);
                div_row = {1'b0, cursor_row_reg};
            end
            PS_LF: begin
                div_num = '0;
                div_row = row_next_line;
            end
            PS_CR: begin
                div_num = '0;
                div_row = {1'b0, cursor_row_reg};
            end
            PS_TAB: begin
                div_num = 11'(cursor_col_reg) + 11'(gw_reg) * 11'(TAB_STOP);
                div_row = {1'b0, cursor_row_reg};
            end
            PS_GLYPH: begin
                div_num = 11'(wcol_reg) + 11'(gw_reg);
                div_row = wrow_reg;
            end
            default: begin
                div_num = {1'b0, cursor_col_reg};
                div_row = {1'b0, cursor_row_reg};
            end
        endcase
    end

    rgt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctl.div_start),
        .num     (div_num),
        .divisor (w_eff),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (ctl.div_start) begin
            row_base_reg <= div_row;
        end
    end

    assign row_sum = 13'(row_base_reg) + 13'(div_quot);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end else if (ctl.place) begin
            cursor_col_reg <= div_rem;
            cursor_row_reg <= (row_sum > 13'(ROW_MAX)) ? ROW_MAX : row_sum[10:0];
        end
    end

    // wrap to next line, then back to top
    assign wrap_col_sum = 11'(cursor_col_reg) + 11'(gw_reg);
    assign wrap_row_sum = 13'(wrow_reg) + 13'(gh_reg);

    always_ff @(posedge aclk) begin
        if (ctl.wrap1) begin
            if (wrap_col_sum > w_eff) begin
                wcol_reg <= '0;
                wrow_reg <= row_next_line;
            end else begin
                wcol_reg <= cursor_col_reg;
                wrow_reg <= {1'b0, cursor_row_reg};
            end
        end else if (ctl.wrap2) begin
            if (wrap_row_sum > 13'(h_eff)) begin
                wcol_reg <= '0;
                wrow_reg <= '0;
            end
        end
    end

    assign open_addr = 25'(prod_reg) + 25'(wcol_reg);

    // pixel walker
    assign pix_addr = {1'b0, draw_addr_reg} + 22'(row_pos_reg);
    assign emit     = paint_reg && (pix_addr < {1'b0, area_reg});
    assign out_free = !out_valid_reg || out_ready;
    assign rp_inc   = {1'b0, row_pos_reg} + 9'd1;
    assign row_end  = rp_inc >= {1'b0, row_size_reg};
    assign da_step  = {1'b0, draw_addr_reg} + 22'(w_eff);
    assign da_next  = (da_step > {1'b0, ADDR_MAX}) ? ADDR_MAX : da_step[20:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            draw_addr_reg    <= '0;
            row_pos_reg      <= '0;
            row_size_reg     <= '0;
            glyph_active_reg <= 1'b0;
        end else begin
            if (ctl.clr_glyph) begin
                glyph_active_reg <= 1'b0;
            end
            if (ctl.open_glyph) begin
                draw_addr_reg    <= (open_addr > 25'(ADDR_MAX)) ? ADDR_MAX
                                                                : open_addr[20:0];
                row_pos_reg      <= '0;
                row_size_reg     <= gw_reg;
                glyph_active_reg <= 1'b1;
            end else if (ctl.pix_step) begin
                if (row_end) begin
                    row_pos_reg   <= '0;
                    draw_addr_reg <= da_next;
                end else begin
                    row_pos_reg <= rp_inc[7:0];
                end
            end
        end
    end

    // output staging
    assign load_out = (ctl.pix_step && emit && pend_valid_reg) || ctl.flush;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (ctl.pix_step && emit) begin
                pend_valid_reg <= 1'b1;
            end else if (ctl.flush) begin
                pend_valid_reg <= 1'b0;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.pix_step && emit) begin
            pend_addr_reg <= pix_addr[19:0];
        end
        if (load_out) begin
            out_addr_reg  <= pend_addr_reg;
            out_color_reg <= color_reg;
            out_last_reg  <= ctl.flush;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_address = out_addr_reg;
    assign out_color   = out_color_reg;
    assign out_last    = out_last_reg;

    always_comb begin
        sts.item_cmd     = cmd_reg;
        sts.char_kind    = classify(char_reg);
        sts.glyph_big    = prod_reg >= {3'b0, area_reg};
        sts.glyph_active = glyph_active_reg;
        sts.div_done     = div_done;
        sts.run_done     = (run_left_reg == '0);
        sts.pix_stall    = emit && pend_valid_reg && !out_free;
        sts.pend_valid   = pend_valid_reg;
        sts.out_free     = out_free;
    end

endmodule

[hdl/rgt_ctrl.sv]
// rgt_ctrl: sequencer of the glyph text renderer; issues datapath commands.
// Depends on rgt_pkg.
module rgt_ctrl
    import rgt_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  rgt_sts_t sts,
    output rgt_ctl_t ctl
);

    state_t state_reg, state_next;
    logic   final_reg, final_next;   // placement ends the item

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        ctl        = '0;
        ctl.src    = PS_CURSOR;
        in_ready   = 1'b0;

        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    ctl.accept = 1'b1;
                    state_next = S_AREA;
                end
            end
            S_AREA: begin
                ctl.area_mul = 1'b1;
                case (item_cmd_t'(sts.item_cmd))
                    CMD_CHAR: begin
                        ctl.clr_glyph = 1'b1;
                        state_next    = S_GMUL;
                    end
                    CMD_RUN: begin
                        state_next = sts.glyph_active ? S_RUN : S_IDLE;
                    end
                    CMD_SET: begin
                        ctl.clr_glyph = 1'b1;
                        ctl.div_start = 1'b1;
                        ctl.src       = PS_SETPOS;
                        final_next    = 1'b1;
                        state_next    = S_DIV;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_GMUL: begin
                ctl.glyph_mul = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK: begin
                if (sts.char_kind == CK_INVALID || sts.glyph_big) begin
                    state_next = S_IDLE;
                end else begin
                    // normalize the stored cursor first
                    ctl.div_start = 1'b1;
                    ctl.src       = PS_CURSOR;
                    final_next    = 1'b0;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                if (sts.div_done) begin
                    ctl.place  = 1'b1;
                    state_next = final_reg ? S_IDLE : S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                final_next = 1'b1;
                case (sts.char_kind)
                    CK_SPACE: begin
                        ctl.div_start = 1'b1;
                        ctl.src       = PS_SPACE;
                        state_next    = S_DIV;
                    end
                    CK_LF: begin
                        ctl.div_start = 1'b1;
                        ctl.src       = PS_LF;
                        state_next    = S_DIV;
                    end
                    CK_CR: begin
                        ctl.div_start = 1'b1;
                        ctl.src       = PS_CR;
                        state_next    = S_DIV;
                    end
                    CK_TAB: begin
                        ctl.div_start = 1'b1;
                        ctl.src       = PS_TAB;
                        state_next    = S_DIV;
                    end
                    CK_GLYPH: state_next = S_WRAP1;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_WRAP1: begin
                ctl.wrap1  = 1'b1;
                state_next = S_WRAP2;
            end
            S_WRAP2: begin
                ctl.wrap2  = 1'b1;
                state_next = S_AMUL;
            end
            S_AMUL: begin
                ctl.addr_mul = 1'b1;
                state_next   = S_OPEN;
            end
            S_OPEN: begin
                ctl.open_glyph = 1'b1;
                ctl.div_start  = 1'b1;
                ctl.src        = PS_GLYPH;
                final_next     = 1'b1;
                state_next     = S_DIV;
            end
            S_RUN: begin
                if (sts.run_done) begin
                    state_next = S_FLUSH;
                end else if (!sts.pix_stall) begin
                    ctl.pix_step = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!sts.pend_valid) begin
                    state_next = S_IDLE;
                end else if (sts.out_free) begin
                    ctl.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

[hdl/rle_glyph_text_renderer_top.sv]
// rle_glyph_text_renderer_top: glyph text renderer top; needs rgt_pkg, rgt_ctrl, rgt_datapath.
// One request in flight. A run steps one pixel per cycle while the output does not stall.
// Cursor set, whitespace and printable glyphs use the 11-step column divider: once for a
//   cursor set, twice for a space, tab, line feed, return or printable glyph.
// Reset (aresetn, synchronous, active low): registers to 320x240, white pen, no line gap;
//   cursor at 0,0, no glyph open, no pixel write pending.
module rle_glyph_text_renderer_top
    import rgt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] char_code, [15:8] glyph_width, [23:16] glyph_height,
    // [31:24] glyph_y_offset, [38:32] run_length, [39] run_draw,
    // [49:40] pos_x, [59:50] pos_y, [63:60] zero
    input  logic [63:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    // pixel writes
    output logic        m_tvalid,
    input  logic        m_tready,
    // [19:0] pixel_address, [35:20] pixel_color, [39:36] zero
    output logic [39:0] m_tdata,
    output logic        m_tlast,   // last_pixel
    // register writes
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    rgt_ctl_t    ctl;
    rgt_sts_t    sts;
    logic [19:0] pix_address;
    logic [15:0] pix_color;

    // sequencer: accepts a request in idle, then walks the datapath through it
    rgt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath: registers, cursor, multiplier, divider, pixel walker, output stage
    rgt_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .sts         (sts),
        .in_data     (s_tdata[59:0]),
        .in_kind     (s_tuser),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (pix_address),
        .out_color   (pix_color),
        .out_last    (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata)
    );

    assign m_tdata = {4'b0, pix_color, pix_address};

`ifndef SYNTH
    // a held write must be flushed before the next request is taken
    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.pend_valid)
        else $error("pixel write still held while accepting a request");

    // a write shown without last always has a successor held back
    a_not_last_has_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> sts.pend_valid)
        else $error("non-final pixel write without a following write");

    // pixels are only walked inside an open glyph
    a_step_needs_glyph: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.pix_step |-> sts.glyph_active)
        else $error("pixel step with no glyph open");

    // a flush always marks the final write of the run
    a_flush_last: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.flush |=> (m_tvalid && m_tlast))
        else $error("flushed write not marked last");
`endif

endmodule

[tb/rle_glyph_text_renderer_top_tb.sv]
// Self-checking bench for rle_glyph_text_renderer_top: text requests in, pixel writes out.
// Needs rgt_pkg and the renderer RTL; a built-in mirror of the renderer predicts every
// pixel write, a clocked driver and monitor move requests and check results.
module rle_glyph_text_renderer_top_tb
    import rgt_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;     // command code the block must ignore
    localparam int         CHUNK_REQS  = 18;       // random requests per register setting
    localparam int         SETTLE      = 80;       // covers a full-length run with no writes
    localparam int         CYCLE_LIMIT = 600000;

    // one text request, fields as they sit in s_tdata / s_tuser
    typedef struct {
        logic [1:0] cmd;
        logic [7:0] code;
        logic [7:0] glyph_w;
        logic [7:0] glyph_h;
        logic [7:0] y_off;
        logic [6:0] run_len;
        logic       run_draw;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        bit         drain;      // hold this request back until all pixel writes are in
    } text_req_t;

    typedef struct {
        logic [19:0] addr;
        logic [15:0] color;
        logic        last;
    } pixel_wr_t;

    // ---------------------------------------------------------------- DUT ports
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = CMD_CHAR;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = CFG_WIDTH;
    logic [15:0] cfg_wdata = '0;

    // ---------------------------------------------------------------- bench state
    text_req_t req_q[$];        // requests waiting for the driver
    pixel_wr_t pixel_q[$];      // predicted pixel writes, oldest first
    text_req_t on_bus;          // request currently offered on s_
    pixel_wr_t want;
    int        pending_cnt   = 0;   // queued or offered, not yet accepted
    int        queued_cnt    = 0;
    int        fail_cnt      = 0;
    int        send_idle_pct = 33;
    int        recv_idle_pct = 71;
    int        cycle_cnt     = 0;

    // renderer mirror: registers (reset values) and drawing state
    logic [10:0] mir_width  = 11'd320;
    logic [10:0] mir_height = 11'd240;
    logic [15:0] mir_color  = 16'hFFFF;
    logic [7:0]  mir_gap    = 8'd0;
    logic [9:0]  crs_col        = '0;
    logic [10:0] crs_row        = '0;
    logic [20:0] glyph_row_addr = '0;  // start of the glyph row being painted
    logic [7:0]  glyph_col      = '0;  // pixel within that row
    logic [7:0]  glyph_span     = '0;  // glyph width
    bit          glyph_open     = 1'b0;

    // out-of-range geometry is clamped to 1..max
    function automatic int eff_width();
        if (mir_width == 0) return 1;
        if (mir_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(mir_width);
    endfunction

    function automatic int eff_height();
        if (mir_height == 0) return 1;
        if (mir_height > MAX_HEIGHT) return MAX_HEIGHT;
        return int'(mir_height);
    endfunction

    // column carries into the row, row saturates
    function automatic void move_cursor(int col, int row);
        int w;
        w = eff_width();
        row = row + col / w;
        col = col % w;
        if (row > int'(ROW_MAX)) row = int'(ROW_MAX);
        crs_col = 10'(col);
        crs_row = 11'(row);
    endfunction

    function automatic void render_char(text_req_t r);
        int     w, h, col, row, gw, gh;
        longint base;
        w = eff_width();
        h = eff_height();
        gw = int'(r.glyph_w);
        gh = int'(r.glyph_h);
        glyph_open = 1'b0;
        // invalid byte or oversized glyph: only closes the glyph
        if (!(r.code >= CHAR_SPACE && r.code <= CHAR_TILDE) && r.code != CHAR_LF
            && r.code != CHAR_CR && r.code != CHAR_TAB) return;
        if (gw * gh >= w * h) return;
        move_cursor(int'(crs_col), int'(crs_row));
        col = int'(crs_col);
        row = int'(crs_row);
        if (r.code == CHAR_SPACE) begin
            move_cursor(col + gw, row);
            return;
        end
        if (r.code == CHAR_LF) begin
            move_cursor(0, row + 1 + int'(mir_gap));
            return;
        end
        if (r.code == CHAR_CR) begin
            move_cursor(0, row);
            return;
        end
        if (r.code == CHAR_TAB) begin
            move_cursor(col + gw * TAB_STOP, row);
            return;
        end
        // printable: wrap right edge, then bottom edge
        if (col + gw > w) begin
            col = 0;
            row = row + 1 + int'(mir_gap);
        end
        if (row + gh > h) begin
            col = 0;
            row = 0;
        end
        base = longint'(row + int'(r.y_off)) * w + col;
        if (base > longint'(ADDR_MAX)) base = longint'(ADDR_MAX);
        glyph_row_addr = 21'(base);
        glyph_col      = '0;
        glyph_span     = r.glyph_w;
        glyph_open     = 1'b1;
        move_cursor(col + gw, row);   // advance from the wrapped spot
    endfunction

    function automatic void render_run(text_req_t r);
        int          w, area, len, i;
        int unsigned a;
        pixel_wr_t   px;
        pixel_wr_t   burst[$];
        if (!glyph_open) return;
        w = eff_width();
        area = w * eff_height();
        len = int'(r.run_len);
        if (len > MAX_RUN) len = MAX_RUN;
        for (i = 0; i < len; i++) begin
            a = int'(glyph_row_addr) + int'(glyph_col);
            // pixels past the frame are skipped but still consumed
            if (r.run_draw && a < area) begin
                px.addr  = 20'(a);
                px.color = mir_color;
                px.last  = 1'b0;
                burst.push_back(px);
            end
            glyph_col = glyph_col + 8'd1;
            if (glyph_col >= glyph_span) begin
                glyph_col = '0;
                if (int'(glyph_row_addr) + w > int'(ADDR_MAX)) glyph_row_addr = ADDR_MAX;
                else glyph_row_addr = 21'(int'(glyph_row_addr) + w);
            end
        end
        if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
        foreach (burst[k]) pixel_q.push_back(burst[k]);
    endfunction

    function automatic void render_request(text_req_t r);
        case (r.cmd)
            CMD_CHAR: render_char(r);
            CMD_RUN:  render_run(r);
            CMD_SET: begin
                glyph_open = 1'b0;
                move_cursor(int'(r.pos_x), int'(r.pos_y));
            end
            default: ;
        endcase
    endfunction

    // ---------------------------------------------------------------- request builders
    // unrelated fields stay random so the block must ignore them
    function automatic text_req_t rand_req();
        text_req_t r;
        r.cmd      = 2'($urandom_range(2));
        r.code     = 8'($urandom);
        r.glyph_w  = 8'($urandom);
        r.glyph_h  = 8'($urandom);
        r.y_off    = 8'($urandom);
        r.run_len  = 7'($urandom);
        r.run_draw = 1'($urandom);
        r.pos_x    = 10'($urandom);
        r.pos_y    = 10'($urandom);
        r.drain    = 1'b0;
        return r;
    endfunction

    function automatic text_req_t char_req(logic [7:0] code, logic [7:0] gw, logic [7:0] gh,
                                           logic [7:0] yoff);
        text_req_t r;
        r = rand_req();
        r.cmd = CMD_CHAR;
        r.code = code;
        r.glyph_w = gw;
        r.glyph_h = gh;
        r.y_off = yoff;
        return r;
    endfunction

    function automatic text_req_t run_req(logic [6:0] len, logic draw);
        text_req_t r;
        r = rand_req();
        r.cmd = CMD_RUN;
        r.run_len = len;
        r.run_draw = draw;
        return r;
    endfunction

    function automatic text_req_t set_req(logic [9:0] x, logic [9:0] y);
        text_req_t r;
        r = rand_req();
        r.cmd = CMD_SET;
        r.pos_x = x;
        r.pos_y = y;
        return r;
    endfunction

    function automatic void queue_req(text_req_t r);
        req_q.push_back(r);
        pending_cnt++;
        queued_cnt++;
    endfunction

    // printable glyph followed by skip/paint runs that roughly cover its area
    function automatic void queue_glyph();
        text_req_t r;
        int        gw, gh, total, covered, len, n;
        logic      draw;
        gw = $urandom_range(10);
        gh = $urandom_range(12);
        if ($urandom_range(9) == 0) gw = $urandom_range(255);
        if ($urandom_range(9) == 0) gh = $urandom_range(255);
        r = char_req(8'($urandom_range(8'h7E, 8'h21)), 8'(gw), 8'(gh),
                     8'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(3)));
        r.drain = ($urandom_range(9) == 0);
        queue_req(r);
        total = gw * gh + $urandom_range(3);
        draw = ($urandom_range(3) == 0);   // fonts normally open with a skip run
        covered = 0;
        n = 0;
        while (covered < total && n < 8) begin
            len = ($urandom_range(15) == 0) ? $urandom_range(127, 65) : $urandom_range(24);
            queue_req(run_req(7'(len), draw));
            covered += len;
            draw = !draw;
            n++;
        end
    endfunction

    // cursor moves, whitespace, bad bytes, stray runs, unused command
    function automatic void queue_noise();
        text_req_t r;
        r = rand_req();
        case ($urandom_range(5))
            0: r.cmd = CMD_SET;
            1: begin
                r.cmd = CMD_CHAR;
                case ($urandom_range(3))
                    0:       r.code = CHAR_SPACE;
                    1:       r.code = CHAR_LF;
                    2:       r.code = CHAR_CR;
                    default: r.code = CHAR_TAB;
                endcase
                if ($urandom_range(3) != 0) r.glyph_h = 8'($urandom_range(3));
            end
            2: begin
                r.cmd = CMD_CHAR;
                r.code = $urandom_range(1) ? 8'($urandom_range(8'hFF, 8'h7F))
                                           : 8'($urandom_range(8'h1F));
            end
            3: r.cmd = CMD_RUN;
            4: r.cmd = CMD_UNUSED;
            default: ;
        endcase
        queue_req(r);
    endfunction

    // register write; only called with the renderer idle
    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_WIDTH:  mir_width  = val[10:0];
            CFG_HEIGHT: mir_height = val[10:0];
            CFG_COLOR:  mir_color  = val;
            CFG_GAP:    mir_gap    = val[7:0];
            default: ;
        endcase
    endtask

    // all requests taken, all writes seen, then let the last request finish
    task automatic wait_idle();
        while (pending_cnt != 0 || pixel_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------- DUT
    rle_glyph_text_renderer_top dut (.*);

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Driver: predict on acceptance, then offer the next request (or idle).
    // A drain request waits for every predicted pixel write to drain first.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                render_request(on_bus);
                pending_cnt--;
            end
            if (!s_tvalid || s_tready) begin
                if (req_q.size() != 0 && !(req_q[0].drain && pixel_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    on_bus = req_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {4'b0, on_bus.pos_y, on_bus.pos_x, on_bus.run_draw,
                                 on_bus.run_len, on_bus.y_off, on_bus.glyph_h,
                                 on_bus.glyph_w, on_bus.code};
                    s_tuser  <= on_bus.cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: random backpressure; each pixel write checked against the oldest prediction.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pixel_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: unexpected pixel write addr %h color %h last %b",
                                 $time, m_tdata[19:0], m_tdata[35:20], m_tlast);
                end else begin
                    want = pixel_q.pop_front();
                    if (m_tdata[19:0] !== want.addr || m_tdata[35:20] !== want.color
                        || m_tlast !== want.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                            $display("%0t: pixel write mismatch addr %h/%h color %h/%h last %b/%b",
                                     $time, want.addr, m_tdata[19:0], want.color,
                                     m_tdata[35:20], want.last, m_tlast);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Stimulus: directed requests at reset settings, then six register settings
    // with random requests each. Idle mix: sender 33/receiver 71, then swapped,
    // then no idling at all.
    initial begin
        int          k, i, start;
        logic [15:0] scr_w[6], scr_h[6], pen[6], gap[6];
        scr_w = '{16'd40, 16'd1024, 16'd0,     16'd2047,  16'd17, 16'd320};
        scr_h = '{16'd30, 16'd1024, 16'd2047,  16'd0,     16'd64, 16'd240};
        pen   = '{16'($urandom), 16'h0000, 16'hFFFF, 16'h5A5A,
                  16'($urandom), 16'($urandom)};
        gap   = '{16'd1, 16'd255, 16'd0, 16'd3, 16'd7, 16'd2};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed, 320x240 white pen, no gap
        begin
            text_req_t r;
            r = rand_req();
            r.cmd = CMD_UNUSED;
            queue_req(r);
        end
        queue_req(run_req(7'd5, 1'b1));                   // no glyph open: ignored
        queue_req(set_req(10'd1023, 10'd1023));           // column carries into row
        queue_req(char_req(8'h41, 8'd8, 8'd12, 8'd2));    // past bottom: back to top
        queue_req(run_req(7'd0, 1'b1));
        queue_req(run_req(7'd127, 1'b1));                 // clipped to MAX_RUN
        queue_req(run_req(7'd3, 1'b0));
        queue_req(run_req(7'd29, 1'b1));
        queue_req(char_req(CHAR_SPACE, 8'd255, 8'd0, 8'd0));
        queue_req(char_req(CHAR_TAB, 8'd255, 8'd1, 8'd0));
        queue_req(char_req(CHAR_LF, 8'd0, 8'd0, 8'd0));
        queue_req(char_req(CHAR_CR, 8'd3, 8'd3, 8'd0));
        queue_req(char_req(8'h7F, 8'd1, 8'd1, 8'd0));     // invalid byte closes glyph
        queue_req(run_req(7'd8, 1'b1));
        queue_req(char_req(8'h00, 8'd1, 8'd1, 8'd0));
        queue_req(char_req(8'hFF, 8'd1, 8'd1, 8'd0));
        queue_req(char_req(8'h1F, 8'd1, 8'd1, 8'd0));
        queue_req(char_req(8'h21, 8'd0, 8'd5, 8'd0));     // zero width: every pixel ends a row
        queue_req(run_req(7'd10, 1'b1));
        queue_req(char_req(CHAR_TILDE, 8'd255, 8'd255, 8'd255));
        queue_req(run_req(7'd64, 1'b1));                  // lies below the frame
        queue_req(set_req(10'd0, 10'd0));
        begin
            text_req_t r;
            r = char_req(8'h57, 8'd255, 8'd1, 8'd0);
            r.drain = 1'b1;
            queue_req(r);
        end
        queue_req(run_req(7'd100, 1'b1));
        queue_req(char_req(8'h40, 8'd100, 8'd2, 8'd1));   // right-edge wrap
        queue_req(run_req(7'd50, 1'b1));

        for (k = 0; k < 6; k++) begin
            wait_idle();
            write_reg(CFG_WIDTH, scr_w[k]);
            write_reg(CFG_HEIGHT, scr_h[k]);
            write_reg(CFG_COLOR, pen[k]);
            write_reg(CFG_GAP, gap[k]);
            @(negedge aclk);
            send_idle_pct = (k < 2) ? 33 : (k < 4) ? 71 : 0;
            recv_idle_pct = (k < 2) ? 71 : (k < 4) ? 33 : 0;
            if (k == 1) begin
                // full screen, gap 255: saturate the cursor row with line feeds,
                // then push a zero-width glyph's draw address to its ceiling
                queue_req(set_req(10'd0, 10'd1023));
                for (i = 0; i < 5; i++) queue_req(char_req(CHAR_LF, 8'd0, 8'd0, 8'd0));
                queue_req(set_req(10'd0, 10'd1023));
                queue_req(char_req(8'h48, 8'd0, 8'd1, 8'd255));
                for (i = 0; i < 14; i++) queue_req(run_req(7'd64, 1'b0));
                queue_req(run_req(7'd64, 1'b1));
            end
            start = queued_cnt;
            while (queued_cnt - start < CHUNK_REQS) begin
                if ($urandom_range(9) < 7) queue_glyph();
                else queue_noise();
            end
        end

        wait_idle();
        if (fail_cnt == 0 && pixel_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
hdl/rgt_pkg.sv
hdl/rgt_div.sv
hdl/rgt_datapath.sv
hdl/rgt_ctrl.sv
hdl/rle_glyph_text_renderer_top.sv
tb/rle_glyph_text_renderer_top_tb.sv
